@@ rtl/q24_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// q24 fixed-point alu package
// opcodes and word types used by the top level and the testbench
// ----------------------------------------------------------------------------
package q24_pkg;

	localparam int unsigned CmdWidth = 4;
	localparam int unsigned WordWidth = 32;

	typedef enum logic [CmdWidth-1:0] {
		OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
		OP_EQ = 4'd4, OP_NE = 4'd5, OP_GE = 4'd6, OP_LE = 4'd7,
		OP_GT = 4'd8, OP_LT = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
		OP_INC = 4'd12, OP_DEC = 4'd13, OP_FROM_INT = 4'd14, OP_TO_INT = 4'd15
	} op_t;

	typedef struct packed {
		logic [CmdWidth-1:0] cmd;
		logic signed [WordWidth-1:0] operand_a;
		logic signed [WordWidth-1:0] operand_b;
	} in_word_t;

	typedef struct packed {
		logic signed [WordWidth-1:0] result;
		logic flag;
		logic div_zero;
	} out_word_t;

endpackage
`default_nettype wire

@@ rtl/q24_div_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// q24 divider cell
// one restoring divide step per cycle; hands the partial remainder on
// ----------------------------------------------------------------------------
module q24_div_cell #(
	parameter int unsigned NUM_WIDTH = 40,
	parameter int unsigned DEN_WIDTH = 32
) (
	input  wire logic                 clk,
	input  wire logic [DEN_WIDTH:0]   rem_in,
	input  wire logic [NUM_WIDTH-1:0] num_in,
	input  wire logic [DEN_WIDTH-1:0] den_in,
	output logic      [DEN_WIDTH:0]   rem_q,
	output logic      [NUM_WIDTH-1:0] num_q,
	output logic      [DEN_WIDTH-1:0] den_q
);
	logic [DEN_WIDTH+1:0] shifted;
	logic [DEN_WIDTH+1:0] diff;
	logic                 take;

	// quotient bits enter the low end of num as dividend bits leave the top
	always_comb begin
		shifted = {rem_in, num_in[NUM_WIDTH-1]};
		diff = shifted - {2'b00, den_in};
		take = (shifted >= {2'b00, den_in});
	end

	always_ff @(posedge clk) begin
		rem_q <= take ? diff[DEN_WIDTH:0] : shifted[DEN_WIDTH:0];
		num_q <= {num_in[NUM_WIDTH-2:0], take};
		den_q <= den_in;
	end
endmodule
`default_nettype wire

@@ rtl/q24_8_fixed_point_alu.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// q24.8 fixed-point alu
// signed fixed-point add, sub, mul, div, compare, min/max and conversions
// ----------------------------------------------------------------------------
// One word is taken every cycle (busy is always low) and its result leaves
// the output register with strobe high for one cycle; the receiver cannot
// hold results off, so each result must be taken in the cycle it is shown.
// The latency is set by the divider: a row of WORD_WIDTH+FRAC_BITS cells,
// each doing one restoring quotient bit, plus an input stage and an output
// stage. The multiplier product stage runs beside the first cell. All other
// opcodes ride a delay line beside the row so every result has the same
// latency and order is kept.
module q24_8_fixed_point_alu #(
	parameter int unsigned FRAC_BITS  = 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire q24_pkg::in_word_t   in_word,
	output logic                     busy,
	output logic                     strobe,
	output q24_pkg::out_word_t       out_word
);
	localparam int unsigned WORD_WIDTH = q24_pkg::WordWidth;
	localparam int unsigned W  = WORD_WIDTH;
	localparam int unsigned NW = WORD_WIDTH + FRAC_BITS;
	localparam int unsigned NC = NW;
	localparam int unsigned LAT = NC + 2;

	typedef struct packed {
		logic [W-1:0] res;
		logic         flag;
		logic         neg;
		logic         is_div;
		logic         dz;
	} side_t;

	logic           acc;
	logic [W-1:0]   a, b;
	q24_pkg::op_t   op;
	logic [W-1:0]   mag_a, mag_b;
	logic           lt_ab, lt_ba;
	side_t          side_c;

	assign busy = 1'b0;
	assign acc = start;
	assign a = W'(in_word.operand_a);
	assign b = W'(in_word.operand_b);
	assign op = q24_pkg::op_t'(in_word.cmd);
	assign mag_a = a[W-1] ? (~a + 1'b1) : a;
	assign mag_b = b[W-1] ? (~b + 1'b1) : b;
	assign lt_ab = $signed(a) < $signed(b);
	assign lt_ba = $signed(b) < $signed(a);

	always_comb begin
		side_c = '0;
		side_c.neg = a[W-1] ^ b[W-1];
		unique case (op)
			q24_pkg::OP_ADD: side_c.res = a + b;
			q24_pkg::OP_SUB: side_c.res = a - b;
			q24_pkg::OP_MUL: side_c.res = '0;
			q24_pkg::OP_DIV: begin
				side_c.is_div = (b != '0);
				side_c.dz = (b == '0);
			end
			q24_pkg::OP_EQ: side_c.flag = (a == b);
			q24_pkg::OP_NE: side_c.flag = (a != b);
			q24_pkg::OP_GE: side_c.flag = !lt_ab;
			q24_pkg::OP_LE: side_c.flag = !lt_ba;
			q24_pkg::OP_GT: side_c.flag = lt_ba;
			q24_pkg::OP_LT: side_c.flag = lt_ab;
			q24_pkg::OP_MIN: side_c.res = lt_ab ? a : b;
			q24_pkg::OP_MAX: side_c.res = lt_ba ? a : b;
			q24_pkg::OP_INC: side_c.res = a + 1'b1;
			q24_pkg::OP_DEC: side_c.res = a - 1'b1;
			q24_pkg::OP_FROM_INT: side_c.res = a << FRAC_BITS;
			q24_pkg::OP_TO_INT: side_c.res = W'($signed(a) >>> FRAC_BITS);
			default: side_c.res = '0;
		endcase
	end

	// input stage
	side_t          side_s1;
	logic           vld_s1;
	logic           mul_s1;
	logic [W-1:0]   ma_s1, mb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		side_s1 <= side_c;
		mul_s1 <= (op == q24_pkg::OP_MUL);
		ma_s1 <= mag_a;
		mb_s1 <= mag_b;
	end

	// multiplier: product registered, then handed down the side line
	logic [2*W-1:0] prod;
	logic [2*W-1:0] sprod;
	side_t          side_s2;
	assign prod = {{W{1'b0}}, ma_s1} * {{W{1'b0}}, mb_s1};
	assign sprod = side_s1.neg ? (~prod + 1'b1) : prod;

	always_ff @(posedge clk) begin
		side_s2 <= side_s1;
		if (mul_s1) begin
			side_s2.res <= sprod[FRAC_BITS +: W];
		end
	end

	// divider row
	logic [W:0]    rem_c [NC+1];
	logic [NW-1:0] num_c [NC+1];
	logic [W-1:0]  den_c [NC+1];
	side_t         side_d [NC+1];
	logic          vld_d  [NC+1];

	assign rem_c[0] = '0;
	assign num_c[0] = {ma_s1, {FRAC_BITS{1'b0}}};
	assign den_c[0] = mb_s1;

	genvar gi;
	generate
		for (gi = 0; gi < NC; gi++) begin : g_cell
			q24_div_cell #(.NUM_WIDTH(NW), .DEN_WIDTH(W)) u_cell (
				.clk    (clk),
				.rem_in (rem_c[gi]),
				.num_in (num_c[gi]),
				.den_in (den_c[gi]),
				.rem_q  (rem_c[gi+1]),
				.num_q  (num_c[gi+1]),
				.den_q  (den_c[gi+1])
			);
		end
	endgenerate

	// side line moves in step with the divider row; the mul stage is its first
	assign side_d[0] = side_s2;
	assign vld_d[0] = vld_s1;

	generate
		for (gi = 0; gi < NC; gi++) begin : g_side
			always_ff @(posedge clk) begin
				if (gi == 0) begin
					side_d[gi+1] <= side_d[0];
				end else begin
					side_d[gi+1] <= side_d[gi];
				end
			end
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_d[gi+1] <= 1'b0;
				end else begin
					vld_d[gi+1] <= vld_d[gi];
				end
			end
		end
	endgenerate

	// the side line starts one stage behind the div data (after the mul
	// stage), so it is tapped one stage earlier than the row output
	logic [W-1:0] quo;
	side_t        side_end;
	logic         vld_end;
	assign quo = num_c[NC][W-1:0];
	assign side_end = side_d[NC-1];
	assign vld_end = vld_d[NC];

	// side_d[NC-1] holds the item whose quotient is now at the row end
	logic [W-1:0] res_c;
	assign res_c = side_end.is_div ? (side_end.neg ? (~quo + 1'b1) : quo) : side_end.res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= vld_end;
		end
	end

	always_ff @(posedge clk) begin
		out_word.result <= $signed(res_c);
		out_word.flag <= side_end.flag;
		out_word.div_zero <= side_end.dz;
	end

	assert property (@(posedge clk) disable iff (!arst_n) busy == 1'b0)
		else $error("busy raised");
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !(out_word.flag && out_word.div_zero))
		else $error("flag and div_zero together");
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && out_word.div_zero |-> out_word.result == '0)
		else $error("div by zero result not zero");
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && out_word.flag |-> out_word.result == '0)
		else $error("compare result not zero");
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_d[NC] |-> $past(vld_s1, LAT - 2))
		else $error("pipeline valid lost");
endmodule
`default_nettype wire

@@ tb/sv/tb_q24_8_fixed_point_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q24.8 fixed-point alu testbench
// directed table of edge cases then random words, each result checked in
// order against the table value or, where none, a behavioral q24.8 predictor
// ----------------------------------------------------------------------------
module tb_q24_8_fixed_point_alu;

	localparam int FRAC = 8;
	localparam int LATENCY = 41;
	localparam int N_RANDOM = 1100;

	typedef struct {
		q24_pkg::op_t cmd;
		logic signed [31:0] a;
		logic signed [31:0] b;
		bit known;
		q24_pkg::out_word_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	q24_pkg::in_word_t in_word = '0;
	logic busy;
	logic strobe;
	q24_pkg::out_word_t out_word;

	q24_pkg::out_word_t pending_results[$];
	int mismatches = 0;
	int sender_idle_pct = 13;
	stim_row_t dir_rows[$];

	q24_8_fixed_point_alu dut (
		.clk(clk), .arst_n(arst_n), .start(start), .in_word(in_word),
		.busy(busy), .strobe(strobe), .out_word(out_word)
	);

	always #5 clk = ~clk;

	function automatic q24_pkg::out_word_t fx_compute(q24_pkg::op_t cmd,
			logic signed [31:0] a, logic signed [31:0] b);
		q24_pkg::out_word_t r;
		logic signed [63:0] prod;
		logic signed [63:0] num;
		logic signed [63:0] quo;
		r = '0;
		case (cmd)
			q24_pkg::OP_ADD: r.result = a + b;
			q24_pkg::OP_SUB: r.result = a - b;
			q24_pkg::OP_MUL: begin
				prod = 64'(a) * 64'(b);
				r.result = 32'(prod >>> FRAC);
			end
			q24_pkg::OP_DIV: begin
				if (b == 0) begin
					r.div_zero = 1'b1;
				end else begin
					// widened dividend, quotient truncates toward zero
					num = 64'(a) <<< FRAC;
					quo = num / 64'(b);
					r.result = 32'(quo);
				end
			end
			q24_pkg::OP_EQ: r.flag = (a == b);
			q24_pkg::OP_NE: r.flag = (a != b);
			q24_pkg::OP_GE: r.flag = (a >= b);
			q24_pkg::OP_LE: r.flag = (a <= b);
			q24_pkg::OP_GT: r.flag = (a > b);
			q24_pkg::OP_LT: r.flag = (a < b);
			q24_pkg::OP_MIN: r.result = (a < b) ? a : b;
			q24_pkg::OP_MAX: r.result = (b < a) ? a : b;
			q24_pkg::OP_INC: r.result = a + 32'sd1;
			q24_pkg::OP_DEC: r.result = a - 32'sd1;
			q24_pkg::OP_FROM_INT: r.result = a <<< FRAC;
			default: r.result = a >>> FRAC;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, q24_pkg::out_word_t got,
			q24_pkg::out_word_t want);
		$display("mismatch %s: got result=%h flag=%b dz=%b want result=%h flag=%b dz=%b",
			what, got.result, got.flag, got.div_zero, want.result, want.flag,
			want.div_zero);
		mismatches++;
	endtask

	// result checker
	always @(posedge clk) begin
		q24_pkg::out_word_t want;
		if (arst_n && strobe) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected word", out_word, '0);
			end else begin
				want = pending_results.pop_front();
				if (out_word.result !== want.result || out_word.flag !== want.flag
						|| out_word.div_zero !== want.div_zero)
					report_mismatch("field", out_word, want);
			end
		end
	end

	task automatic send_word(q24_pkg::op_t cmd, logic signed [31:0] a,
			logic signed [31:0] b, bit known, q24_pkg::out_word_t want);
		q24_pkg::out_word_t pred;
		while ($urandom_range(99, 0) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		in_word <= '{cmd: cmd, operand_a: a, operand_b: b};
		pred = fx_compute(cmd, a, b);
		if (known && pred != want)
			$display("table row disagrees with predictor for op %s", cmd.name());
		pending_results.push_back(known ? want : pred);
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_operand();
		case ($urandom_range(5, 0))
			0: return 32'sh8000_0000 + $urandom_range(3, 0);
			1: return 32'sh7fff_fffc + $urandom_range(3, 0);
			2: return $signed(32'($urandom_range(2047, 0)) - 32'd1024);
			3: return $signed(32'($urandom_range(65535, 0)) - 32'd32768) <<< 4;
			default: return $signed($urandom());
		endcase
	endfunction

	task automatic add_row(q24_pkg::op_t c, logic signed [31:0] a,
			logic signed [31:0] b, bit k, logic signed [31:0] res, logic f, logic dz);
		stim_row_t r;
		r.cmd = c; r.a = a; r.b = b; r.known = k;
		r.want = '{result: res, flag: f, div_zero: dz};
		dir_rows.push_back(r);
	endtask

	initial begin
		q24_pkg::op_t c;
		logic signed [31:0] a;
		logic signed [31:0] b;
		add_row(q24_pkg::OP_ADD, 32'sh7fff_ffff, 32'sd1, 1'b1, 32'sh8000_0000, 1'b0, 1'b0);
		add_row(q24_pkg::OP_SUB, 32'sh8000_0000, 32'sd1, 1'b1, 32'sh7fff_ffff, 1'b0, 1'b0);
		add_row(q24_pkg::OP_MUL, 32'sh0000_0100, 32'sh0000_0100, 1'b1, 32'sh0000_0100,
			1'b0, 1'b0);
		add_row(q24_pkg::OP_MUL, 32'sh8000_0000, 32'sh8000_0000, 1'b0, 32'sd0, 1'b0, 1'b0);
		add_row(q24_pkg::OP_MUL, -32'sd1, 32'sd1, 1'b1, -32'sd1, 1'b0, 1'b0);
		add_row(q24_pkg::OP_DIV, 32'sh0000_1234, 32'sd0, 1'b1, 32'sd0, 1'b0, 1'b1);
		add_row(q24_pkg::OP_DIV, 32'sh8000_0000, -32'sh100, 1'b1, 32'sh8000_0000,
			1'b0, 1'b0);
		add_row(q24_pkg::OP_DIV, -32'sd1, 32'sh7fff_ffff, 1'b0, 32'sd0, 1'b0, 1'b0);
		add_row(q24_pkg::OP_DIV, 32'sh7fff_ffff, 32'sd1, 1'b0, 32'sd0, 1'b0, 1'b0);
		add_row(q24_pkg::OP_EQ, 32'sd5, 32'sd5, 1'b1, 32'sd0, 1'b1, 1'b0);
		add_row(q24_pkg::OP_NE, 32'sd5, 32'sd5, 1'b1, 32'sd0, 1'b0, 1'b0);
		add_row(q24_pkg::OP_GE, 32'sh8000_0000, 32'sh7fff_ffff, 1'b1, 32'sd0, 1'b0, 1'b0);
		add_row(q24_pkg::OP_LE, 32'sh8000_0000, 32'sh7fff_ffff, 1'b1, 32'sd0, 1'b1, 1'b0);
		add_row(q24_pkg::OP_GT, 32'sh7fff_ffff, 32'sh8000_0000, 1'b1, 32'sd0, 1'b1, 1'b0);
		add_row(q24_pkg::OP_LT, 32'sd3, 32'sd3, 1'b1, 32'sd0, 1'b0, 1'b0);
		add_row(q24_pkg::OP_MIN, 32'sh8000_0000, 32'sh7fff_ffff, 1'b1, 32'sh8000_0000,
			1'b0, 1'b0);
		add_row(q24_pkg::OP_MAX, 32'sh8000_0000, 32'sh7fff_ffff, 1'b1, 32'sh7fff_ffff,
			1'b0, 1'b0);
		add_row(q24_pkg::OP_INC, 32'sh7fff_ffff, 32'sd9, 1'b1, 32'sh8000_0000, 1'b0, 1'b0);
		add_row(q24_pkg::OP_DEC, 32'sh8000_0000, -32'sd9, 1'b1, 32'sh7fff_ffff, 1'b0, 1'b0);
		add_row(q24_pkg::OP_FROM_INT, 32'sh00ff_ffff, 32'sd0, 1'b1, 32'shffff_ff00,
			1'b0, 1'b0);
		add_row(q24_pkg::OP_FROM_INT, 32'sh8000_0001, 32'sd0, 1'b1, 32'sh0000_0100,
			1'b0, 1'b0);
		add_row(q24_pkg::OP_TO_INT, -32'sd1, 32'sd0, 1'b1, -32'sd1, 1'b0, 1'b0);
		add_row(q24_pkg::OP_TO_INT, 32'sh8000_0000, 32'sd0, 1'b1, 32'shff80_0000,
			1'b0, 1'b0);
		add_row(q24_pkg::OP_TO_INT, 32'sh7fff_ffff, 32'sd0, 1'b1, 32'sh007f_ffff,
			1'b0, 1'b0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_word(dir_rows[i].cmd, dir_rows[i].a, dir_rows[i].b,
				dir_rows[i].known, dir_rows[i].want);

		for (int phase = 0; phase < 3; phase++) begin
			sender_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 63 : 0;
			for (int n = 0; n < N_RANDOM / 3; n++) begin
				c = q24_pkg::op_t'($urandom_range(15, 0));
				a = rand_operand();
				b = ($urandom_range(15, 0) == 0) ? 32'sd0 : rand_operand();
				if ($urandom_range(7, 0) == 0) b = a;
				send_word(c, a, b, 1'b0, '0);
			end
		end
		start <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
